### hw/rtl/dfrt_pkg.sv
`timescale 1ns / 1ps

package dfrt_pkg;

	// table geometry
	localparam int ID_COUNT    = 256;
	localparam int IDX_W       = $clog2(ID_COUNT);
	localparam int MAX_SEGMENT = 1024;

	// field widths
	localparam int PID_W  = 8;
	localparam int SIZE_W = 16;
	localparam int SEG_W  = 11;
	localparam int SOCK_W = 31;

	// table entry: expected size over received count
	localparam int ENTRY_W = 2 * SIZE_W;

	typedef enum logic [2:0] {
		ACT_WHOLE    = 3'd0,
		ACT_STORED   = 3'd1,
		ACT_DONE     = 3'd2,
		ACT_RESTART  = 3'd3,
		ACT_LOST     = 3'd4,
		ACT_OVERFLOW = 3'd5
	} action_t;

	typedef struct packed {
		logic [SIZE_W-1:0] expected;
		logic [SIZE_W-1:0] received;
	} entry_t;

endpackage

### hw/rtl/dfrt_ifs.sv
`timescale 1ns / 1ps

// segment header channel
interface dfrt_seg_if;
	logic                         valid;
	logic                         ready;
	logic [dfrt_pkg::PID_W-1:0]   packet_id;
	logic [dfrt_pkg::SIZE_W-1:0]  packet_size;
	logic [dfrt_pkg::SIZE_W-1:0]  segment_offset;
	logic [dfrt_pkg::SEG_W-1:0]   segment_size;
	logic [dfrt_pkg::SOCK_W-1:0]  socket_id;

	modport source (output valid, packet_id, packet_size, segment_offset, segment_size,
		socket_id, input ready);
	modport sink (input valid, packet_id, packet_size, segment_offset, segment_size,
		socket_id, output ready);
endinterface

// result channel
interface dfrt_res_if;
	logic                         valid;
	logic                         ready;
	logic [2:0]                   action;
	logic [dfrt_pkg::PID_W-1:0]   out_packet_id;
	logic [dfrt_pkg::SIZE_W-1:0]  write_offset;
	logic [dfrt_pkg::SEG_W-1:0]   write_size;
	logic [dfrt_pkg::SIZE_W-1:0]  ready_size;
	logic [dfrt_pkg::SOCK_W-1:0]  out_socket_id;

	modport source (output valid, action, out_packet_id, write_offset, write_size,
		ready_size, out_socket_id, input ready);
	modport sink (input valid, action, out_packet_id, write_offset, write_size,
		ready_size, out_socket_id, output ready);
endinterface

### hw/rtl/dfrt_ram.sv
`timescale 1ns / 1ps

module dfrt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### hw/rtl/datagram_fragment_reassembly_tracker.sv
`timescale 1ns / 1ps

// channel  dir  payload
// seg      in   packet_id, packet_size, segment_offset, segment_size, socket_id
// res      out  action, out_packet_id, write_offset, write_size, ready_size,
//               out_socket_id
//
// The table entry is read from the RAM on accept and, for a stored or
// restarted packet, written back when the result is registered.
// Only one item is in flight at a time, so read and write never meet on
// the same entry. Valid flags sit in flip-flops and reset clears them at
// once; no clearing pass. A stalled result holds the item in flight and
// the next item waits.

module datagram_fragment_reassembly_tracker (
	input  logic        clk,
	input  logic        arst_n,
	dfrt_seg_if.sink    seg,
	dfrt_res_if.source  res
);

	localparam int SUM_W = dfrt_pkg::SIZE_W + 1;

	// item in flight
	logic                            busy_s1;
	logic [dfrt_pkg::PID_W-1:0]      pid_s1;
	logic [dfrt_pkg::SIZE_W-1:0]     psz_s1;
	logic [dfrt_pkg::SIZE_W-1:0]     soff_s1;
	logic [dfrt_pkg::SEG_W-1:0]      ssz_s1;
	logic [dfrt_pkg::SOCK_W-1:0]     sock_s1;

	logic [dfrt_pkg::ID_COUNT-1:0]   entry_valid_q;

	// result register
	logic                            out_valid_q;
	dfrt_pkg::action_t               action_q;
	logic [dfrt_pkg::PID_W-1:0]      pid_q;
	logic [dfrt_pkg::SIZE_W-1:0]     woff_q;
	logic [dfrt_pkg::SEG_W-1:0]      wsz_q;
	logic [dfrt_pkg::SIZE_W-1:0]     ready_q;
	logic [dfrt_pkg::SOCK_W-1:0]     sock_q;

	logic                            accept;
	logic                            finish;
	logic [dfrt_pkg::IDX_W-1:0]      rd_idx;
	logic [dfrt_pkg::IDX_W-1:0]      idx_s1;
	logic [dfrt_pkg::ENTRY_W-1:0]    rd_word;
	dfrt_pkg::entry_t                rd_entry;
	dfrt_pkg::entry_t                wr_entry;
	logic                            wr_en;
	logic                            live;

	dfrt_pkg::action_t               action_d;
	logic [dfrt_pkg::SIZE_W-1:0]     woff_d;
	logic [dfrt_pkg::SEG_W-1:0]      wsz_d;
	logic [dfrt_pkg::SIZE_W-1:0]     ready_d;
	logic                            set_valid;
	logic                            clr_valid;
	logic [dfrt_pkg::SIZE_W-1:0]     exp_sel;
	logic [dfrt_pkg::SIZE_W-1:0]     rcv_sel;
	logic [SUM_W-1:0]                end_sum;
	logic [SUM_W-1:0]                rcv_sum;

	// handshakes
	assign seg.ready = !busy_s1;
	assign accept    = seg.valid && seg.ready;
	assign finish    = busy_s1 && (!out_valid_q || res.ready);

	// table index
	assign rd_idx = seg.packet_id[dfrt_pkg::IDX_W-1:0];
	assign idx_s1 = pid_s1[dfrt_pkg::IDX_W-1:0];

	dfrt_ram #(
		.WIDTH (dfrt_pkg::ENTRY_W),
		.DEPTH (dfrt_pkg::ID_COUNT)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (idx_s1),
		.wr_data (wr_entry),
		.rd_en   (accept),
		.rd_addr (rd_idx),
		.rd_data (rd_word)
	);

	assign rd_entry = dfrt_pkg::entry_t'(rd_word);
	assign live     = entry_valid_q[idx_s1];

	// decision on the entry read back
	always_comb begin
		exp_sel   = (soff_s1 == '0) ? psz_s1 : rd_entry.expected;
		rcv_sel   = (soff_s1 == '0) ? '0 : rd_entry.received;
		end_sum   = {1'b0, soff_s1} + SUM_W'(ssz_s1);
		rcv_sum   = {1'b0, rcv_sel} + SUM_W'(ssz_s1);
		action_d  = dfrt_pkg::ACT_OVERFLOW;
		woff_d    = '0;
		wsz_d     = '0;
		ready_d   = '0;
		set_valid = 1'b0;
		clr_valid = 1'b0;
		wr_entry.expected = exp_sel;
		wr_entry.received = rcv_sum[dfrt_pkg::SIZE_W-1:0];
		if (ssz_s1 > dfrt_pkg::SEG_W'(dfrt_pkg::MAX_SEGMENT)) begin
			action_d = dfrt_pkg::ACT_OVERFLOW;
		end else if (psz_s1 == dfrt_pkg::SIZE_W'(ssz_s1)) begin
			action_d = dfrt_pkg::ACT_WHOLE;
			wsz_d    = ssz_s1;
			ready_d  = psz_s1;
		end else if (!live && soff_s1 != '0) begin
			action_d = dfrt_pkg::ACT_LOST;
		end else if (end_sum > {1'b0, exp_sel} || rcv_sum > {1'b0, exp_sel}) begin
			action_d = dfrt_pkg::ACT_OVERFLOW;
		end else begin
			woff_d = soff_s1;
			wsz_d  = ssz_s1;
			if (rcv_sum == {1'b0, exp_sel}) begin
				action_d  = dfrt_pkg::ACT_DONE;
				ready_d   = exp_sel;
				clr_valid = 1'b1;
			end else begin
				action_d  = (live && soff_s1 == '0) ? dfrt_pkg::ACT_RESTART
					: dfrt_pkg::ACT_STORED;
				set_valid = 1'b1;
			end
		end
	end

	assign wr_en = finish && set_valid;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1       <= 1'b0;
			out_valid_q   <= 1'b0;
			entry_valid_q <= '0;
		end else begin
			if (accept) begin
				busy_s1 <= 1'b1;
			end else if (finish) begin
				busy_s1 <= 1'b0;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (finish && set_valid) begin
				entry_valid_q[idx_s1] <= 1'b1;
			end else if (finish && clr_valid) begin
				entry_valid_q[idx_s1] <= 1'b0;
			end
		end
	end

	// item in flight payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pid_s1  <= seg.packet_id;
			psz_s1  <= seg.packet_size;
			soff_s1 <= seg.segment_offset;
			ssz_s1  <= seg.segment_size;
			sock_s1 <= seg.socket_id;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (finish) begin
			action_q <= action_d;
			pid_q    <= pid_s1;
			woff_q   <= woff_d;
			wsz_q    <= wsz_d;
			ready_q  <= ready_d;
			sock_q   <= sock_s1;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.action        = action_q;
	assign res.out_packet_id = pid_q;
	assign res.write_offset  = woff_q;
	assign res.write_size    = wsz_q;
	assign res.ready_size    = ready_q;
	assign res.out_socket_id = sock_q;

endmodule
